### hdl/span_coord_stream_decoder_core_macros.svh
// ---------------------------------------------------------------------------
// Span coordinate stream decoder assertion macros
// Shorthand for clocked concurrent assertions used by the checker.
// ---------------------------------------------------------------------------
`ifndef SPAN_COORD_STREAM_DECODER_CORE_MACROS_SVH
`define SPAN_COORD_STREAM_DECODER_CORE_MACROS_SVH

// Assertion that is off while reset is held.
`define SCD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that also checks during reset.
`define SCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/scd_pkg.sv
// ---------------------------------------------------------------------------
// Span coordinate stream decoder package
// Field widths, result status codes and the structs passed between stages.
// ---------------------------------------------------------------------------
package scd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned OutIdW = 48;
  localparam int unsigned CoordW = 32;
  localparam int unsigned AccW   = 64;

  localparam int unsigned InDepth  = 2;
  localparam int unsigned OutDepth = 4;

  typedef enum logic [1:0] {
    ST_NODE      = 2'd0,
    ST_END       = 2'd1,
    ST_BAD       = 2'd2,
    ST_AFTER_END = 2'd3
  } status_t;

  // Classified input byte, as queued between front and back.
  typedef struct packed {
    logic              restart;
    logic [OutIdW-1:0] restart_id;
    logic [ByteW-1:0]  data;
    logic              cont;      // varint continuation bit
    logic              tail_ok;   // byte fits as the last byte of a 64-bit varint
  } item_t;

  typedef struct packed {
    logic [OutIdW-1:0] node_id;
    logic [CoordW-1:0] x_coord;
    logic [CoordW-1:0] y_coord;
    status_t           status;
  } result_t;

endpackage

### hdl/scd_fifo.sv
// ---------------------------------------------------------------------------
// Span coordinate stream decoder queue
// Small register queue with push/full and pop/empty sides.
// ---------------------------------------------------------------------------
module scd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CntW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### hdl/scd_front.sv
// ---------------------------------------------------------------------------
// Span coordinate stream decoder front end
// Accepts stream bytes, classifies varint bits and queues them for the back.
// ---------------------------------------------------------------------------
module scd_front
  import scd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [ByteW-1:0]  data_byte,
  input  logic              restart,
  input  logic [OutIdW-1:0] restart_id,
  output item_t             item,
  output logic              item_valid,
  input  logic              item_pop
);

  item_t in_item;
  logic  q_empty;

  always_comb begin
    in_item.restart    = restart;
    in_item.restart_id = restart_id;
    in_item.data       = data_byte;
    in_item.cont       = data_byte[ByteW-1];
    in_item.tail_ok    = (data_byte[ByteW-1:1] == '0);
  end

  scd_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (InDepth)
  ) u_in_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (in_item),
    .full  (full),
    .pop   (item_pop),
    .rdata (item),
    .empty (q_empty)
  );

  assign item_valid = !q_empty;

endmodule

### hdl/scd_back.sv
// ---------------------------------------------------------------------------
// Span coordinate stream decoder back end
// Parses span headers, fixed coordinates and zigzag deltas; emits results.
// ---------------------------------------------------------------------------
module scd_back
  import scd_pkg::*;
#(
  parameter int unsigned ID_BITS = 48
) (
  input  logic    clk,
  input  logic    rst_n,
  input  item_t   item,
  input  logic    item_valid,
  output logic    item_pop,
  input  logic    res_full,
  output logic    res_push,
  output result_t res
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_FIX_X,
    PH_FIX_Y,
    PH_DELTA_X,
    PH_DELTA_Y,
    PH_DELTA_Y_XBAD,
    PH_LOST
  } phase_t;

  localparam logic [AccW-1:0] IdMask = {AccW{1'b1}} >> (AccW - ID_BITS);
  localparam int unsigned VarMax = 9;

  phase_t             phase_r, phase_nxt, phase_e;
  logic [1:0]         fbc_r, fbc_nxt, fbc_e;
  logic [AccW-1:0]    acc_r, acc_nxt, acc_e;
  logic [3:0]         shift_r, shift_nxt, shift_e;
  logic [ID_BITS-1:0] nodes_r, nodes_nxt, nodes_dec;
  logic [ID_BITS-1:0] id_r, id_nxt, id_e, id_inc;
  logic [CoordW-1:0]  x_r, x_nxt;
  logic [CoordW-1:0]  y_r, y_nxt;
  logic               ended_r, ended_nxt;

  logic               go;
  logic [5:0]         sh7;
  logic [AccW-1:0]    acc_v, acc_f;
  logic               vb_fail, vb_more;
  logic [AccW-1:0]    half;
  logic [CoordW-1:0]  base, delta, sum;
  logic               dbad;
  logic               bad_span;

  assign go       = item_valid && !res_full;
  assign item_pop = go;

  always_comb begin
    // restart drops any partial span and restarts the header parse
    if (item.restart) begin
      id_e    = ID_BITS'(item.restart_id);
      phase_e = PH_HEADER;
      acc_e   = '0;
      shift_e = '0;
      fbc_e   = '0;
    end else begin
      id_e    = id_r;
      phase_e = phase_r;
      acc_e   = acc_r;
      shift_e = shift_r;
      fbc_e   = fbc_r;
    end

    // one varint byte
    sh7 = 6'({2'b00, shift_e} * 6'd7);
    if (shift_e >= 4'(VarMax)) begin
      vb_fail = !item.tail_ok;
      vb_more = 1'b0;
      acc_v   = acc_e | {item.data[0], {(AccW-1){1'b0}}};
    end else begin
      vb_fail = 1'b0;
      vb_more = item.cont;
      acc_v   = acc_e | (AccW'(item.data[ByteW-2:0]) << sh7);
    end

    // fixed little-endian byte
    acc_f = acc_e | (AccW'(item.data) << {fbc_e, 3'b000});

    // zigzag delta on the running coordinate of this phase
    base  = (phase_e == PH_DELTA_X) ? x_r : y_r;
    half  = {1'b0, acc_v[AccW-1:1]};
    delta = half[CoordW-1:0] ^ {CoordW{acc_v[0]}};
    sum   = base + delta;
    if (acc_v[0]) begin
      dbad = (half >= AccW'(base));
    end else begin
      dbad = (half > {{(AccW-CoordW){1'b0}}, ~base});
    end

    bad_span  = ((half & ~IdMask) != '0);
    id_inc    = id_e + 1'b1;
    nodes_dec = nodes_r - 1'b1;
  end

  always_comb begin
    phase_nxt = phase_r;
    fbc_nxt   = fbc_r;
    acc_nxt   = acc_r;
    shift_nxt = shift_r;
    nodes_nxt = nodes_r;
    id_nxt    = id_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    ended_nxt = ended_r;
    res_push  = 1'b0;
    res       = '{node_id: OutIdW'(id_e), x_coord: '0, y_coord: '0, status: ST_BAD};

    if (go) begin
      priority if (!item.restart && ended_r) begin
        res_push       = 1'b1;
        res.status     = ST_AFTER_END;
      end else if (phase_e == PH_LOST) begin
        // ignore bytes until restart
      end else begin
        id_nxt    = id_e;
        ended_nxt = 1'b0;
        phase_nxt = phase_e;
        acc_nxt   = acc_e;
        shift_nxt = shift_e;
        fbc_nxt   = fbc_e;
        unique case (phase_e)
          PH_HEADER: begin
            if (vb_fail) begin
              res_push = 1'b1;
            end else if (vb_more) begin
              acc_nxt   = acc_v;
              shift_nxt = shift_e + 1'b1;
            end else begin
              acc_nxt   = '0;
              shift_nxt = '0;
              if (acc_v[0]) begin
                if (half == '0) begin
                  ended_nxt  = 1'b1;
                  res_push   = 1'b1;
                  res.status = ST_END;
                end else begin
                  id_nxt = ID_BITS'(AccW'(id_e) + half);
                end
              end else if (bad_span) begin
                res_push = 1'b1;
              end else begin
                nodes_nxt = ID_BITS'(half);
                fbc_nxt   = '0;
                phase_nxt = PH_FIX_X;
              end
            end
          end
          PH_FIX_X, PH_FIX_Y: begin
            if (fbc_e != 2'd3) begin
              acc_nxt = acc_f;
              fbc_nxt = fbc_e + 1'b1;
            end else begin
              acc_nxt = '0;
              fbc_nxt = '0;
              if (phase_e == PH_FIX_X) begin
                x_nxt     = acc_f[CoordW-1:0];
                phase_nxt = PH_FIX_Y;
              end else begin
                y_nxt       = acc_f[CoordW-1:0];
                res_push    = 1'b1;
                res.x_coord = x_r;
                res.y_coord = acc_f[CoordW-1:0];
                res.status  = ST_NODE;
                id_nxt      = id_inc;
                phase_nxt   = (nodes_r != '0) ? PH_DELTA_X : PH_HEADER;
              end
            end
          end
          PH_DELTA_X: begin
            if (vb_fail) begin
              res_push = 1'b1;
            end else if (vb_more) begin
              acc_nxt   = acc_v;
              shift_nxt = shift_e + 1'b1;
            end else begin
              x_nxt     = sum;
              acc_nxt   = '0;
              shift_nxt = '0;
              phase_nxt = dbad ? PH_DELTA_Y_XBAD : PH_DELTA_Y;
            end
          end
          PH_DELTA_Y, PH_DELTA_Y_XBAD: begin
            if (vb_fail) begin
              res_push = 1'b1;
            end else if (vb_more) begin
              acc_nxt   = acc_v;
              shift_nxt = shift_e + 1'b1;
            end else begin
              y_nxt       = sum;
              acc_nxt     = '0;
              shift_nxt   = '0;
              res_push    = 1'b1;
              res.x_coord = x_r;
              res.y_coord = sum;
              res.status  = (dbad || phase_e == PH_DELTA_Y_XBAD) ? ST_BAD : ST_NODE;
              id_nxt      = id_inc;
              nodes_nxt   = nodes_dec;
              phase_nxt   = (nodes_dec != '0) ? PH_DELTA_X : PH_HEADER;
            end
          end
          default: begin
          end
        endcase
        // malformed: report once, then drop bytes until restart
        if (res_push && res.status == ST_BAD && res.x_coord == '0 && res.y_coord == '0 &&
            (vb_fail || (phase_e == PH_HEADER && !acc_v[0] && bad_span))) begin
          acc_nxt   = '0;
          shift_nxt = '0;
          fbc_nxt   = '0;
          phase_nxt = PH_LOST;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      fbc_r   <= '0;
      acc_r   <= '0;
      shift_r <= '0;
      nodes_r <= '0;
      id_r    <= '0;
      x_r     <= '0;
      y_r     <= '0;
      ended_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      fbc_r   <= fbc_nxt;
      acc_r   <= acc_nxt;
      shift_r <= shift_nxt;
      nodes_r <= nodes_nxt;
      id_r    <= id_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      ended_r <= ended_nxt;
    end
  end

endmodule

### hdl/span_coord_stream_decoder_core.sv
// ---------------------------------------------------------------------------
// Span coordinate stream decoder
// Decodes a varint/zigzag span stream into node id and coordinate results.
// ---------------------------------------------------------------------------
// Takes one stream byte per cycle and sustains that rate as long as results
// are popped: a byte is registered in the input queue, decoded as it leaves
// that queue, and its result, if any, is registered in the result queue that
// drives the out_ ports. A two-entry input queue feeds the decode stage, which
// handles each byte with one shift-or on the varint accumulator and one 64-bit
// compare and 32-bit add for the zigzag delta; a four-entry result queue lets
// the input keep flowing while a result waits. Node ids are kept modulo
// 2**ID_BITS and shown as their low 48 bits.
module span_coord_stream_decoder_core
  import scd_pkg::*;
#(
  parameter int unsigned ID_BITS = 48
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [ByteW-1:0]  in_data_byte,
  input  logic              in_restart,
  input  logic [OutIdW-1:0] in_restart_id,
  output logic              empty,
  input  logic              pop,
  output logic [OutIdW-1:0] out_node_id,
  output logic [CoordW-1:0] out_x_coord,
  output logic [CoordW-1:0] out_y_coord,
  output logic [1:0]        out_status
);

  item_t   item;
  logic    item_valid, item_pop;
  logic    res_full, res_push;
  result_t res, res_head;

  scd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .data_byte  (in_data_byte),
    .restart    (in_restart),
    .restart_id (in_restart_id),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop)
  );

  scd_back #(
    .ID_BITS (ID_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res)
  );

  scd_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OutDepth)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_head),
    .empty (empty)
  );

  assign out_node_id = res_head.node_id;
  assign out_x_coord = res_head.x_coord;
  assign out_y_coord = res_head.y_coord;
  assign out_status  = res_head.status;

endmodule

### hdl/scd_checker.sv
// ---------------------------------------------------------------------------
// Span coordinate stream decoder checker
// Port-level assertions, bound to the decoder top level.
// ---------------------------------------------------------------------------
`include "span_coord_stream_decoder_core_macros.svh"

module scd_checker
  import scd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input logic [OutIdW-1:0] out_node_id,
  input logic [CoordW-1:0] out_x_coord,
  input logic [CoordW-1:0] out_y_coord,
  input logic [1:0]        out_status
);

  // the result queue comes out of reset empty and the input queue not full
  `SCD_ASSERT_ALWAYS(a_reset_drained, clk, !rst_n |=> (empty && !full), "queues not drained after reset")

  // end marker and byte-after-end carry zero coordinates
  `SCD_ASSERT(a_end_zero, clk, rst_n, (!empty && (out_status == ST_END || out_status == ST_AFTER_END)) |-> (out_x_coord == '0 && out_y_coord == '0), "end result with nonzero coordinates")

  // a waiting result holds until popped
  `SCD_ASSERT(a_res_hold, clk, rst_n, (!empty && !pop) |=> (!empty && $stable(out_node_id) && $stable(out_x_coord) && $stable(out_y_coord) && $stable(out_status)), "waiting result changed")

endmodule

bind span_coord_stream_decoder_core scd_checker u_scd_checker (.*);

### verif/tb_top.sv
// ---------------------------------------------------------------------------
// Span coordinate stream decoder testbench
// Feeds encoded span streams (well-formed, broken and noise) one byte per
// request, predicts every node, end and error result in a scoreboard class
// and checks each popped result field by field, under random idling on both
// sides and a long output stall.
// ---------------------------------------------------------------------------
module tb_top;
  import scd_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned TailCycles    = 20;
  localparam int unsigned PhaseBytes    = 560;

  typedef struct {
    logic [ByteW-1:0]  b;
    logic              rs;
    logic [OutIdW-1:0] rid;
  } stream_byte_t;

  // Predicts the decoder byte by byte and holds the nodes still due.
  class node_ledger;
    typedef enum logic [2:0] {
      WAIT_HDR, ABS_X, ABS_Y, DLT_X, DLT_Y, DLT_Y_XOOR, DROPPED
    } parse_ph_t;
    typedef enum {VARINT_MORE, VARINT_DONE, VARINT_FAIL} varint_t;

    parse_ph_t         ph;
    logic [1:0]        fix_cnt;
    logic [63:0]       acc;
    int unsigned       vshift;
    logic [OutIdW-1:0] nodes_left;
    logic [OutIdW-1:0] cur_id;
    logic [31:0]       x_run;
    logic [31:0]       y_run;
    bit                ended;
    result_t           nodes_due[$];
    int unsigned       errors;
    int unsigned       checked;

    function new();
      ph = WAIT_HDR;
      fix_cnt = 0;
      acc = 0;
      vshift = 0;
      nodes_left = 0;
      cur_id = 0;
      x_run = 0;
      y_run = 0;
      ended = 0;
      errors = 0;
      checked = 0;
    endfunction

    function int unsigned pending();
      return nodes_due.size();
    endfunction

    function void due(logic [OutIdW-1:0] id, logic [31:0] x, logic [31:0] y, status_t st);
      result_t r;
      r.node_id = id;
      r.x_coord = x;
      r.y_coord = y;
      r.status  = st;
      nodes_due = {nodes_due, r};
    endfunction

    function void clear_acc();
      acc = 0;
      vshift = 0;
    endfunction

    function varint_t take_varint(logic [7:0] b);
      if (vshift >= 9) begin
        if (b >= 8'd2) return VARINT_FAIL;
        acc[63] = acc[63] | b[0];
        return VARINT_DONE;
      end
      acc = acc | ({57'd0, b[6:0]} << (7 * vshift));
      if (b[7]) begin
        vshift++;
        return VARINT_MORE;
      end
      return VARINT_DONE;
    endfunction

    // Zigzag delta add; flag a true sum outside 0..2^32-1, keep the wrapped value.
    function logic [31:0] add_zigzag(logic [31:0] base, logic [63:0] zz, output bit oor);
      logic [63:0] half;
      half = zz >> 1;
      if (zz[0]) begin
        oor = (half + 64'd1) > {32'd0, base};
        return base - half[31:0] - 32'd1;
      end
      oor = half > (64'h0000_0000_FFFF_FFFF - {32'd0, base});
      return base + half[31:0];
    endfunction

    function void take_byte(logic [7:0] b, logic rs, logic [OutIdW-1:0] rid);
      varint_t     r;
      logic [63:0] hdr;
      logic [63:0] n;
      bit          xo;
      bit          yo;
      if (rs) begin
        cur_id = rid;
        ended = 0;
        ph = WAIT_HDR;
        fix_cnt = 0;
        clear_acc();
      end else if (ended) begin
        due(cur_id, 0, 0, ST_AFTER_END);
        return;
      end else if (ph == DROPPED) begin
        return;
      end
      case (ph)
        WAIT_HDR: begin
          r = take_varint(b);
          if (r == VARINT_MORE) return;
          if (r == VARINT_DONE) begin
            hdr = acc;
            clear_acc();
            n = hdr >> 1;
            if (hdr[0]) begin
              if (n == 0) begin
                ended = 1;
                due(cur_id, 0, 0, ST_END);
              end else begin
                cur_id = cur_id + n[OutIdW-1:0];
              end
              return;
            end
            if (n[63:OutIdW] == 0) begin
              nodes_left = n[OutIdW-1:0];
              fix_cnt = 0;
              ph = ABS_X;
              return;
            end
          end
        end
        ABS_X, ABS_Y: begin
          acc = acc | ({56'd0, b} << (8 * fix_cnt));
          if (fix_cnt < 2'd3) begin
            fix_cnt++;
            return;
          end
          fix_cnt = 0;
          if (ph == ABS_X) begin
            x_run = acc[31:0];
            clear_acc();
            ph = ABS_Y;
            return;
          end
          y_run = acc[31:0];
          clear_acc();
          due(cur_id, x_run, y_run, ST_NODE);
          cur_id = cur_id + 1'b1;
          ph = (nodes_left != 0) ? DLT_X : WAIT_HDR;
          return;
        end
        DLT_X: begin
          r = take_varint(b);
          if (r == VARINT_MORE) return;
          if (r == VARINT_DONE) begin
            x_run = add_zigzag(x_run, acc, xo);
            clear_acc();
            ph = xo ? DLT_Y_XOOR : DLT_Y;
            return;
          end
        end
        DLT_Y, DLT_Y_XOOR: begin
          r = take_varint(b);
          if (r == VARINT_MORE) return;
          if (r == VARINT_DONE) begin
            y_run = add_zigzag(y_run, acc, yo);
            clear_acc();
            due(cur_id, x_run, y_run, (ph == DLT_Y_XOOR || yo) ? ST_BAD : ST_NODE);
            cur_id = cur_id + 1'b1;
            nodes_left = nodes_left - 1'b1;
            ph = (nodes_left != 0) ? DLT_X : WAIT_HDR;
            return;
          end
        end
        default: return;
      endcase
      // malformed: report once, then drop bytes until a restart
      clear_acc();
      fix_cnt = 0;
      ph = DROPPED;
      due(cur_id, 0, 0, ST_BAD);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t: result %0d %s: got 0x%0h, want 0x%0h", $time, checked, what, got, want);
      errors++;
    endtask

    task check_node(logic [OutIdW-1:0] id, logic [31:0] x, logic [31:0] y, logic [1:0] st);
      result_t want;
      checked++;
      if (nodes_due.size() == 0) begin
        report_mismatch("arrived with nothing due, node_id", id, 0);
        return;
      end
      want = nodes_due.pop_front();
      if (id !== want.node_id) report_mismatch("node_id", id, want.node_id);
      if (x !== want.x_coord) report_mismatch("x_coord", x, want.x_coord);
      if (y !== want.y_coord) report_mismatch("y_coord", y, want.y_coord);
      if (st !== want.status) report_mismatch("status", st, want.status);
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic [ByteW-1:0]  in_data_byte = '0;
  logic              in_restart = 1'b0;
  logic [OutIdW-1:0] in_restart_id = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic [OutIdW-1:0] out_node_id;
  logic [CoordW-1:0] out_x_coord;
  logic [CoordW-1:0] out_y_coord;
  logic [1:0]        out_status;

  node_ledger   ledger = new();
  stream_byte_t stream_q[$];
  int unsigned  rcv_idle = 0;
  bit           hold_req = 0;
  bit           hold_done = 0;
  int unsigned  hold_left = 0;
  int unsigned  stall_cycles = 0;

  span_coord_stream_decoder_core DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_data_byte  (in_data_byte),
    .in_restart    (in_restart),
    .in_restart_id (in_restart_id),
    .empty         (empty),
    .pop           (pop),
    .out_node_id   (out_node_id),
    .out_x_coord   (out_x_coord),
    .out_y_coord   (out_y_coord),
    .out_status    (out_status)
  );

  always #5 clk = ~clk;

  // ---- stream building ----
  function automatic logic [OutIdW-1:0] rand48();
    logic [63:0] t;
    t = {$urandom, $urandom};
    return t[OutIdW-1:0];
  endfunction

  function automatic logic [OutIdW-1:0] rand_id();
    case ($urandom_range(7))
      0: return '1;
      1: return '0;
      2: return {40'hFF_FFFF_FFFF, 8'($urandom)};
      default: return rand48();
    endcase
  endfunction

  function automatic void add_byte(logic [7:0] b, logic rs, logic [OutIdW-1:0] rid);
    stream_byte_t s;
    s.b = b;
    s.rs = rs;
    s.rid = rid;
    stream_q = {stream_q, s};
  endfunction

  function automatic void put(logic [7:0] b);
    add_byte(b, 1'b0, rand48());
  endfunction

  function automatic void put_varint(logic [63:0] v);
    do begin
      put({(v > 64'd127), v[6:0]});
      v = v >> 7;
    end while (v != 0);
  endfunction

  function automatic void put_u32(logic [31:0] v);
    for (int i = 0; i < 4; i++) put(v[8*i +: 8]);
  endfunction

  // Nine continuation bytes and a tenth byte that breaks a 64-bit varint unless tail_ok is set.
  function automatic void put_overlong(bit tail_ok);
    repeat (9) put(8'h80 | 8'($urandom_range(127)));
    put(tail_ok ? 8'($urandom_range(1)) : 8'($urandom_range(2, 255)));
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] rand_delta();
    longint d;
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel == 9) return {$urandom, $urandom};
    if (sel < 5) d = longint'($urandom_range(0, 200)) - 100;
    else if (sel < 7) d = longint'($urandom_range(0, 2097152)) - 1048576;
    else d = longint'(int'($urandom));
    return 64'(d <<< 1) ^ 64'(d >>> 63);
  endfunction

  function automatic void mark_restart(int unsigned start);
    stream_q[start].rs = 1'b1;
    stream_q[start].rid = rand_id();
  endfunction

  function automatic void gen_stream();
    int unsigned start;
    int unsigned cnt;
    logic [OutIdW-1:0] n;
    start = stream_q.size();
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(3) == 0) begin
        n = ($urandom_range(4) == 0) ? rand48() : OutIdW'($urandom_range(1, 300));
        if (n == 0) n = 1;
        put_varint({15'd0, n, 1'b1});
      end else begin
        cnt = $urandom_range(0, 5);
        put_varint({31'd0, cnt, 1'b0});
        put_u32(rand_coord());
        put_u32(rand_coord());
        repeat (cnt) begin
          put_varint(rand_delta());
          put_varint(rand_delta());
        end
      end
    end
    if ($urandom_range(9) < 7) begin
      put(8'h01);
      repeat ($urandom_range(0, 2)) put(8'($urandom));
    end else if ($urandom_range(1) == 0 && stream_q.size() - start > 3) begin
      // cut the stream short; the next restart drops the partial span
      repeat ($urandom_range(1, 3)) void'(stream_q.pop_back());
    end
    mark_restart(start);
  endfunction

  function automatic void gen_broken(int unsigned kind);
    int unsigned start;
    logic [63:0] hdr;
    start = stream_q.size();
    case (kind)
      0: put_overlong($urandom_range(3) == 0);
      1: begin
        hdr = {$urandom, $urandom};
        hdr[0] = 1'b0;
        if (hdr[63:49] == 0) hdr[49 + $urandom_range(14)] = 1'b1;
        put_varint(hdr);
      end
      default: begin
        put_varint({62'd0, 2'b10});
        put_u32(rand_coord());
        put_u32(rand_coord());
        if ($urandom_range(1)) put_varint(rand_delta());
        put_overlong(1'b0);
      end
    endcase
    repeat ($urandom_range(0, 3)) put(8'($urandom));
    mark_restart(start);
  endfunction

  function automatic void gen_noise();
    repeat ($urandom_range(3, 12)) begin
      add_byte(8'($urandom), $urandom_range(99) < 15, rand_id());
    end
  endfunction

  function automatic void build_random(int unsigned target);
    int unsigned k;
    while (stream_q.size() < target) begin
      k = $urandom_range(99);
      if (k < 70) gen_stream();
      else if (k < 78) gen_broken(0);
      else if (k < 84) gen_broken(1);
      else if (k < 90) gen_broken(2);
      else gen_noise();
    end
  endfunction

  function automatic void load_directed();
    // first node at the top id, so the id wraps after it
    add_byte(8'h02, 1'b1, '1);
    put_u32(32'hFFFF_FFFF);
    put_u32(32'h0000_0000);
    put(8'h02);                 // x + 1 overflows
    put(8'h01);                 // y - 1 underflows
    put(8'h0B);                 // header that skips five ids
    put(8'h01);                 // end marker
    put(8'hA5);                 // byte after end
    add_byte(8'hFF, 1'b1, rand48());
    repeat (8) put(8'hFF);
    put(8'h7E);                 // tenth varint byte too large
    put(8'h01);                 // dropped
  endfunction

  // ---- driving ----
  task automatic send_queued(int unsigned idle_pct);
    stream_byte_t cur;
    bit offered;
    offered = 0;
    while (stream_q.size() > 0 || offered) begin
      @(posedge clk);
      if (offered && !full) begin
        ledger.take_byte(cur.b, cur.rs, cur.rid);
        offered = 0;
      end
      if (!offered) begin
        if (stream_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          cur = stream_q.pop_front();
          offered = 1;
          in_data_byte  <= cur.b;
          in_restart    <= cur.rs;
          in_restart_id <= cur.rid;
          push          <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  endtask

  task automatic drain();
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) ledger.check_node(out_node_id, out_x_coord, out_y_coord, out_status);
      if (hold_req && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int unsigned snd_idle;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    snd_idle = 33;
    rcv_idle = 71;
    load_directed();
    send_queued(snd_idle);
    drain();
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin snd_idle = 33; rcv_idle = 71; end
        1: begin snd_idle = 71; rcv_idle = 33; end
        default: begin snd_idle = 0; rcv_idle = 0; end
      endcase
      build_random(PhaseBytes);
      // stall the output while bytes keep coming, so the input backs up
      if (p == 2) hold_req = 1;
      send_queued(snd_idle);
      drain();
    end
    repeat (TailCycles) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
